// File: rtl/core/lcdser_pkg.sv
// ----------------------------------------------------------------------------
// lcdser_pkg
// Shared types and constants for the 9-bit three-wire lcd command serializer.
// ----------------------------------------------------------------------------
package lcdser_pkg;

    localparam int DATA_W    = 8;
    localparam int BIT_IDX_W = $clog2(DATA_W);
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;
    localparam int PIN_W     = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [BIT_IDX_W-1:0] BIT_TOP = BIT_IDX_W'(DATA_W - 1);

    // tuser code on the input side
    localparam logic CMD_COMMAND = 1'b0;
    localparam logic CMD_PARAM   = 1'b1;

    typedef enum logic {
        KIND_COMMAND = 1'b0,
        KIND_PARAM   = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] data_byte;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLK_HI,
        ST_CS_LO,
        ST_DC_CLK_LO,
        ST_DC_DAT,
        ST_DC_CLK_HI,
        ST_BIT_CLK_LO,
        ST_BIT_DAT,
        ST_BIT_CLK_HI,
        ST_CS_END
    } seq_state_t;

    typedef enum logic [1:0] {
        PIN_CS,
        PIN_CLK,
        PIN_DAT
    } pin_t;

endpackage

// File: rtl/core/nine_bit_spi_lcd_command_serializer_top.sv
// ----------------------------------------------------------------------------
// nine_bit_spi_lcd_command_serializer_top
// Byte-to-pin-write serializer for a three-wire 9-bit lcd link.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte, with tuser set for a parameter and
// clear for a command. The block answers with one output transaction per pin
// write, giving the chip-select, clock and data levels after that write; tlast
// marks the closing chip-select-high write. A command yields 31 transactions
// and a parameter 29. The pin sequencer makes one write per cycle while
// m_tready is held high, and consecutive bytes follow with no gap; a front
// register and a two-entry queue let input bytes be taken while the
// sequencer is still busy.
module nine_bit_spi_lcd_command_serializer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lcdser_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                             s_tuser,  // [0] cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] chip_select, [1] serial_clock, [2] serial_data, [7:3] zero
    output logic [lcdser_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import lcdser_pkg::*;

    q_push_t q_push;
    q_head_t q_head;
    logic    q_ready;
    logic    pop;

    lcdser_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push)
    );

    lcdser_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_ready (q_ready),
        .pop     (pop),
        .q_head  (q_head)
    );

    lcdser_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/core/lcdser_front.sv
// ----------------------------------------------------------------------------
// lcdser_front
// Accepts byte transactions, tags them as command or parameter and pushes
// them into the work queue.
// ----------------------------------------------------------------------------
module lcdser_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcdser_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tuser,
    input  logic                            q_ready,
    output lcdser_pkg::q_push_t             q_push
);
    import lcdser_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    q_entry_t entry_reg;
    logic     take;
    logic     push;

    assign push     = valid_reg && q_ready;
    assign s_tready = !valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            entry_reg.kind      <= (s_tuser == CMD_PARAM) ? KIND_PARAM : KIND_COMMAND;
            entry_reg.data_byte <= s_tdata[DATA_W-1:0];
        end
    end

    assign q_push.valid = push;
    assign q_push.entry = entry_reg;

endmodule

// File: rtl/core/lcdser_queue.sv
// ----------------------------------------------------------------------------
// lcdser_queue
// Small fifo between the front end and the pin sequencer.
// ----------------------------------------------------------------------------
module lcdser_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcdser_pkg::q_push_t q_push,
    output logic                q_ready,
    input  logic                pop,
    output lcdser_pkg::q_head_t q_head
);
    import lcdser_pkg::*;

    q_entry_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               do_push;
    logic               do_pop;

    assign q_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign do_push = q_push.valid && q_ready;
    assign do_pop  = pop && (cnt_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

    assign q_head.valid = (cnt_reg != '0);
    assign q_head.entry = mem_reg[rd_ptr_reg];

endmodule

// File: rtl/core/lcdser_back.sv
// ----------------------------------------------------------------------------
// lcdser_back
// Pin sequencer: walks one queued byte through its chip-select, clock and
// data writes, one write per output transaction.
// ----------------------------------------------------------------------------
module lcdser_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lcdser_pkg::q_head_t              q_head,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lcdser_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import lcdser_pkg::*;

    seq_state_t             state_reg;
    seq_state_t             state_next;
    logic [BIT_IDX_W-1:0]   bit_cnt_reg;
    logic [DATA_W-1:0]      byte_reg;
    kind_t                  kind_reg;
    logic                   cs_reg;
    logic                   clk_reg;
    logic                   dat_reg;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   last_reg;

    logic                   adv;
    logic                   wr_en;
    pin_t                   wr_pin;
    logic                   wr_val;
    logic                   wr_last;

    // the output register is free or being emptied this cycle
    assign adv = !valid_reg || m_tready;

    // write produced in each state
    always_comb begin
        wr_en   = adv;
        wr_pin  = PIN_CLK;
        wr_val  = 1'b0;
        wr_last = 1'b0;
        pop     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                wr_en  = adv && q_head.valid;
                pop    = wr_en;
                wr_pin = PIN_CS;
                wr_val = (q_head.entry.kind == KIND_COMMAND);
            end
            ST_CLK_HI: begin
                wr_pin = PIN_CLK;
                wr_val = 1'b1;
            end
            ST_CS_LO: begin
                wr_pin = PIN_CS;
                wr_val = 1'b0;
            end
            ST_DC_CLK_LO: begin
                wr_pin = PIN_CLK;
                wr_val = 1'b0;
            end
            ST_DC_DAT: begin
                wr_pin = PIN_DAT;
                wr_val = (kind_reg == KIND_PARAM);
            end
            ST_DC_CLK_HI: begin
                wr_pin = PIN_CLK;
                wr_val = 1'b1;
            end
            ST_BIT_CLK_LO: begin
                wr_pin = PIN_CLK;
                wr_val = 1'b0;
            end
            ST_BIT_DAT: begin
                wr_pin = PIN_DAT;
                wr_val = byte_reg[bit_cnt_reg];
            end
            ST_BIT_CLK_HI: begin
                wr_pin = PIN_CLK;
                wr_val = 1'b1;
            end
            ST_CS_END: begin
                wr_pin  = PIN_CS;
                wr_val  = 1'b1;
                wr_last = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        if (wr_en) begin
            unique case (state_reg)
                ST_IDLE: begin
                    state_next = (q_head.entry.kind == KIND_COMMAND) ? ST_CLK_HI : ST_DC_CLK_LO;
                end
                ST_CLK_HI:     state_next = ST_CS_LO;
                ST_CS_LO:      state_next = ST_DC_CLK_LO;
                ST_DC_CLK_LO:  state_next = ST_DC_DAT;
                ST_DC_DAT:     state_next = ST_DC_CLK_HI;
                ST_DC_CLK_HI:  state_next = ST_BIT_CLK_LO;
                ST_BIT_CLK_LO: state_next = ST_BIT_DAT;
                ST_BIT_DAT:    state_next = ST_BIT_CLK_HI;
                ST_BIT_CLK_HI: begin
                    state_next = (bit_cnt_reg == '0) ? ST_CS_END : ST_BIT_CLK_LO;
                end
                ST_CS_END:     state_next = ST_IDLE;
                default:       state_next = ST_IDLE;
            endcase
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            cs_reg    <= 1'b0;
            clk_reg   <= 1'b0;
            dat_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (wr_en) begin
                unique case (wr_pin)
                    PIN_CS:  cs_reg  <= wr_val;
                    PIN_CLK: clk_reg <= wr_val;
                    PIN_DAT: dat_reg <= wr_val;
                    default: cs_reg  <= cs_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            last_reg <= wr_last;
        end
        if (pop) begin
            byte_reg    <= q_head.entry.data_byte;
            kind_reg    <= q_head.entry.kind;
            bit_cnt_reg <= BIT_TOP;
        end else if (wr_en && (state_reg == ST_BIT_CLK_HI)) begin
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - PIN_W){1'b0}}, dat_reg, clk_reg, cs_reg};
    assign m_tlast  = last_reg;

endmodule

// File: rtl/core/lcdser_checker.sv
// ----------------------------------------------------------------------------
// lcdser_checker
// Port-level checks on the pin-write stream, bound to the top level.
// ----------------------------------------------------------------------------
module lcdser_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lcdser_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);
    import lcdser_pkg::*;

    logic m_acc;
    assign m_acc = m_tvalid && m_tready;

    // a stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output changed while stalled");

    // every run closes with chip select high
    a_last_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tdata[0])
        else $error("last write without chip select high");

    // back-to-back writes move at most one pin
    a_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && $past(m_acc))
            |-> ($countones(m_tdata[PIN_W-1:0] ^ $past(m_tdata[PIN_W-1:0])) <= 1))
        else $error("more than one pin changed in one write");

    // data only moves while the clock is low
    a_dat_clk: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && $past(m_acc) && (m_tdata[2] != $past(m_tdata[2]))) |-> !m_tdata[1])
        else $error("data changed with clock high");

endmodule

bind nine_bit_spi_lcd_command_serializer_top lcdser_checker u_lcdser_checker (.*);
